// File: rtl/case_folding_murmur_hash32_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the case-folding hash block
// Concurrent checks on clk with rst_n as disable; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CASE_FOLDING_MURMUR_HASH32_ASSERT_SVH
`define CASE_FOLDING_MURMUR_HASH32_ASSERT_SVH

`ifndef SYNTHESIS
`define CFMH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfmh: property failed");
`define CFMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfmh: sequence property failed");
`else
`define CFMH_ASSERT(label, prop)
`define CFMH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/cfmh_pkg.sv
// ----------------------------------------------------------------------------
// cfmh_pkg
// Shared constants, state codes and control structs of the hash block.
// ----------------------------------------------------------------------------
package cfmh_pkg;

    localparam logic [31:0] MIX_MUL    = 32'h7FD6_52AD;
    localparam logic [31:0] HASH_BASE  = 32'hDEAD_BEEF;
    localparam logic [7:0]  FOLD_LO    = 8'h60;   // exclusive lower bound of 'a'..'z'
    localparam logic [7:0]  FOLD_HI    = 8'h7B;   // exclusive upper bound
    localparam logic [7:0]  FOLD_DELTA = 8'h20;
    localparam int unsigned SHIFT_WORD = 16;
    localparam int unsigned SHIFT_FIN1 = 10;
    localparam int unsigned SHIFT_FIN2 = 17;

    // configuration register indexes
    localparam logic [1:0] CFG_SEED          = 2'd0;
    localparam logic [1:0] CFG_ALREADY_UPPER = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_TAIL,
        S_OUT
    } state_t;

    // which mix round is in flight
    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_TAIL,
        STEP_FIN1,
        STEP_FIN2
    } step_t;

    typedef struct packed {
        logic  take;      // accept the input word
        logic  add_tail;  // acc += pending tail bytes
        logic  mul;       // prod = acc * MIX_MUL
        logic  mix;       // acc = prod ^ (prod >> shift)
        logic  emit;      // load output register, close message
        step_t step;      // selects the mix shift
    } cmd_t;

    typedef struct packed {
        logic word_full;    // input word completes a 4-byte group
        logic item_last;    // input word ends the message
        logic pend_nonzero; // tail bytes pending
        logic out_free;     // output register can take a result this cycle
    } status_t;

endpackage

// File: rtl/cfmh_datapath.sv
// ----------------------------------------------------------------------------
// cfmh_datapath
// Config registers, byte folding/packing, accumulator, shared multiplier
// and output register.
// ----------------------------------------------------------------------------
module cfmh_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [7:0]        data_byte,
    input  logic              has_byte,
    input  logic              last,
    input  logic              out_stall,
    input  cfmh_pkg::cmd_t    cmd,
    output cfmh_pkg::status_t status,
    output logic              out_valid,
    output logic [31:0]       hash_value
);

    logic [31:0] seed_reg, seed_next;
    logic        upper_reg, upper_next;
    logic        big_reg, big_next;

    logic [31:0] acc_reg, acc_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        in_msg_reg, in_msg_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] hash_reg, hash_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] base;
    logic [23:0] pend_eff;
    logic [1:0]  cnt_eff;
    logic [7:0]  byte_f;
    logic [31:0] word;
    logic [31:0] prod_low;
    logic [31:0] mixed;

    // a new message starts from seed + base with nothing pending
    assign base     = in_msg_reg ? acc_reg : seed_reg + cfmh_pkg::HASH_BASE;
    assign pend_eff = in_msg_reg ? pend_reg : 24'd0;
    assign cnt_eff  = in_msg_reg ? cnt_reg : 2'd0;

    assign byte_f = (!upper_reg && data_byte > cfmh_pkg::FOLD_LO
                     && data_byte < cfmh_pkg::FOLD_HI)
                    ? data_byte - cfmh_pkg::FOLD_DELTA : data_byte;

    assign word = big_reg ? {pend_eff[7:0], pend_eff[15:8], pend_eff[23:16], byte_f}
                          : {byte_f, pend_eff};

    // only the low 32 bits of the product are kept
    assign prod_low = acc_reg * cfmh_pkg::MIX_MUL;

    always_comb
    begin
        unique case (cmd.step)
            cfmh_pkg::STEP_FIN1: mixed = prod_reg ^ (prod_reg >> cfmh_pkg::SHIFT_FIN1);
            cfmh_pkg::STEP_FIN2: mixed = prod_reg ^ (prod_reg >> cfmh_pkg::SHIFT_FIN2);
            default:             mixed = prod_reg ^ (prod_reg >> cfmh_pkg::SHIFT_WORD);
        endcase
    end

    always_comb
    begin
        seed_next      = seed_reg;
        upper_next     = upper_reg;
        big_next       = big_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        in_msg_next    = in_msg_reg;
        prod_next      = prod_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            unique case (cfg_index)
                cfmh_pkg::CFG_SEED:          seed_next  = cfg_data;
                cfmh_pkg::CFG_ALREADY_UPPER: upper_next = cfg_data[0];
                cfmh_pkg::CFG_BIG_ENDIAN:    big_next   = cfg_data[0];
                default:                     ;
            endcase
        end

        if (cmd.take)
        begin
            in_msg_next = 1'b1;
            acc_next    = base;
            pend_next   = pend_eff;
            cnt_next    = cnt_eff;
            if (has_byte)
            begin
                if (cnt_eff == 2'd3)
                begin
                    acc_next  = base + word;
                    pend_next = 24'd0;
                    cnt_next  = 2'd0;
                end
                else
                begin
                    cnt_next = cnt_eff + 2'd1;
                    case (cnt_eff)
                        2'd0:    pend_next[7:0]   = byte_f;
                        2'd1:    pend_next[15:8]  = byte_f;
                        default: pend_next[23:16] = byte_f;
                    endcase
                end
            end
        end

        if (cmd.add_tail)
            acc_next = acc_reg + {8'd0, pend_reg};
        if (cmd.mul)
            prod_next = prod_low;
        if (cmd.mix)
            acc_next = mixed;
        if (cmd.emit)
        begin
            hash_next      = acc_reg;
            out_valid_next = 1'b1;
            in_msg_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            upper_reg     <= 1'b0;
            big_reg       <= 1'b0;
            cnt_reg       <= '0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            upper_reg     <= upper_next;
            big_reg       <= big_next;
            cnt_reg       <= cnt_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        pend_reg <= pend_next;
        prod_reg <= prod_next;
        hash_reg <= hash_next;
    end

    assign status.word_full    = has_byte && (cnt_eff == 2'd3);
    assign status.item_last    = last;
    assign status.pend_nonzero = (cnt_reg != 2'd0);
    assign status.out_free     = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

// File: rtl/cfmh_ctrl.sv
// ----------------------------------------------------------------------------
// cfmh_ctrl
// Sequencer: input handshake, mix rounds on the shared multiplier, output.
// ----------------------------------------------------------------------------
`include "case_folding_murmur_hash32_assert.svh"

module cfmh_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cfmh_pkg::status_t status,
    output cfmh_pkg::cmd_t    cmd
);

    cfmh_pkg::state_t state_reg, state_next;
    cfmh_pkg::step_t  step_reg, step_next;
    logic             last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfmh_pkg::S_IDLE;
            step_reg  <= cfmh_pkg::STEP_WORD;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        in_stall     = 1'b1;

        unique case (state_reg)
            cfmh_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take  = 1'b1;
                    last_next = status.item_last;
                    if (status.word_full)
                    begin
                        step_next  = cfmh_pkg::STEP_WORD;
                        state_next = cfmh_pkg::S_MUL;
                    end
                    else if (status.item_last)
                        state_next = cfmh_pkg::S_TAIL;
                end
            end
            cfmh_pkg::S_TAIL:
            begin
                // tail bytes get one extra word round before finalization
                if (status.pend_nonzero)
                begin
                    cmd.add_tail = 1'b1;
                    step_next    = cfmh_pkg::STEP_TAIL;
                end
                else
                    step_next = cfmh_pkg::STEP_FIN1;
                state_next = cfmh_pkg::S_MUL;
            end
            cfmh_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = cfmh_pkg::S_MIX;
            end
            cfmh_pkg::S_MIX:
            begin
                cmd.mix = 1'b1;
                unique case (step_reg)
                    cfmh_pkg::STEP_WORD:
                        state_next = last_reg ? cfmh_pkg::S_TAIL : cfmh_pkg::S_IDLE;
                    cfmh_pkg::STEP_TAIL:
                    begin
                        step_next  = cfmh_pkg::STEP_FIN1;
                        state_next = cfmh_pkg::S_MUL;
                    end
                    cfmh_pkg::STEP_FIN1:
                    begin
                        step_next  = cfmh_pkg::STEP_FIN2;
                        state_next = cfmh_pkg::S_MUL;
                    end
                    default:
                        state_next = cfmh_pkg::S_OUT;
                endcase
            end
            cfmh_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = cfmh_pkg::S_IDLE;
                end
            end
            default:
                state_next = cfmh_pkg::S_IDLE;
        endcase
    end

    `CFMH_ASSERT(a_emit_only_when_free, cmd.emit |-> status.out_free)
    `CFMH_ASSERT_NEXT(a_mul_then_mix, state_reg == cfmh_pkg::S_MUL,
                      state_reg == cfmh_pkg::S_MIX)
    `CFMH_ASSERT_NEXT(a_fin2_to_out,
                      (state_reg == cfmh_pkg::S_MIX) && (step_reg == cfmh_pkg::STEP_FIN2),
                      state_reg == cfmh_pkg::S_OUT)

endmodule

// File: rtl/case_folding_murmur_hash32.sv
// ----------------------------------------------------------------------------
// case_folding_murmur_hash32
// Case-folding MurmurHash1-style 32-bit hash over a byte stream.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//  in      | in_valid, in_stall, data_byte, has_byte, last  | in
//  out     | out_valid, out_stall, hash_value               | out
//
// A byte that does not close a 4-byte group is only accepted; one closing a
// group is accepted, multiplied and xor-shifted on the single shared 32x32
// multiplier. A last word adds a tail-check state, a tail round if tail bytes
// are pending, the FIN1 and FIN2 finalization rounds and an output-register load.
// rst_n clears config to zero and leaves the block idle with no open message.
// in_stall is low only while the sequencer is idle; a finished hash sits in
// the output register while out_stall is high, and the next message is taken
// meanwhile. cfg_ready is always high; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module case_folding_murmur_hash32
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    cfmh_pkg::cmd_t    cmd;
    cfmh_pkg::status_t status;
    logic              cfg_we;

    // config writes are taken every cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    cfmh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cfmh_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .hash_value (hash_value)
    );

endmodule
